// File: src/abpd_pkg.sv
package abpd_pkg;

    typedef enum logic [2:0] {
        EV_CALIBRATED = 3'd0,
        EV_SYNC_LOST  = 3'd1,
        EV_START      = 3'd2,
        EV_LENGTH     = 3'd3,
        EV_PAYLOAD    = 3'd4,
        EV_END_OK     = 3'd5,
        EV_END_BAD    = 3'd6
    } ev_kind_t;

    typedef enum logic [3:0] {
        PH_START   = 4'b0001,
        PH_LEN_HI  = 4'b0010,
        PH_LEN_LO  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } phase_t;

    localparam logic [2:0] REG_CAL_ENABLE  = 3'd0;
    localparam logic [2:0] REG_CAL_PATTERN = 3'd1;
    localparam logic [2:0] REG_SYNC_BYTE   = 3'd2;
    localparam logic [2:0] REG_DUMMY_BYTE  = 3'd3;
    localparam logic [2:0] REG_START_BYTE  = 3'd4;
    localparam logic [2:0] REG_END_BYTE    = 3'd5;
    localparam logic [2:0] REG_SLOTS       = 3'd6;

    localparam logic       RST_CAL_ENABLE  = 1'b1;
    localparam logic [7:0] RST_CAL_PATTERN = 8'hEC;
    localparam logic [7:0] RST_SYNC_BYTE   = 8'hAA;
    localparam logic [7:0] RST_DUMMY_BYTE  = 8'h3C;
    localparam logic [7:0] RST_START_BYTE  = 8'hBE;
    localparam logic [7:0] RST_END_BYTE    = 8'hED;
    localparam logic [7:0] RST_SLOTS       = 8'd16;

    localparam logic [2:0] BITS_FULL_BYTE = 3'd7;
    localparam logic [2:0] BITS_TWO       = 3'd1;
    localparam logic [2:0] BITS_SIX       = 3'd5;
    localparam logic [2:0] BITS_ONE       = 3'd0;

    localparam logic [7:0] ASCII_NINE   = 8'h39;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_A_BIAS = 8'h37;

    typedef struct packed {
        logic       cal_enable;
        logic [7:0] cal_pattern;
        logic [7:0] sync_byte;
        logic [7:0] dummy_byte;
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] slots;
    } cfg_t;

    typedef struct packed {
        ev_kind_t   kind;
        logic [7:0] value;
    } res_t;

    // ascii hex digit, other characters wrap the same way
    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        if (c <= ASCII_NINE)
        begin
            d = c - ASCII_ZERO;
        end
        else
        begin
            d = c - ASCII_A_BIAS;
        end
        return d;
    endfunction

endpackage

// File: src/abpd_core.sv
module abpd_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              rx_bit,
    input  abpd_pkg::cfg_t    cfg,
    output logic              res_valid,
    output abpd_pkg::res_t    res
);

    logic [7:0]       window_reg,   window_next;
    logic [2:0]       bits_reg,     bits_next;
    logic             cal_reg,      cal_next;
    logic             sync_reg,     sync_next;
    logic             aligned_reg,  aligned_next;
    abpd_pkg::phase_t phase_reg,    phase_next;
    logic [7:0]       len_reg,      len_next;
    logic [7:0]       count_reg,    count_next;

    logic [7:0] win;
    logic [7:0] partial;
    logic [7:0] digit;

    assign win     = {window_reg[6:0], rx_bit};
    assign partial = {cfg.sync_byte[5:0], cfg.dummy_byte[7:6]};
    assign digit   = abpd_pkg::hex_digit(win);

    always_comb
    begin
        window_next  = window_reg;
        bits_next    = bits_reg;
        cal_next     = cal_reg;
        sync_next    = sync_reg;
        aligned_next = aligned_reg;
        phase_next   = phase_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        res_valid    = 1'b0;
        res.kind     = abpd_pkg::EV_CALIBRATED;
        res.value    = win;

        if (accept)
        begin
            window_next = win;
            if (cfg.cal_enable && !cal_reg)
            begin
                if (win == cfg.cal_pattern)
                begin
                    cal_next  = 1'b1;
                    res_valid = 1'b1;
                end
            end
            else if (bits_reg != 3'd0)
            begin
                bits_next = bits_reg - 3'd1;
            end
            else if (!aligned_reg)
            begin
                if (!sync_reg)
                begin
                    if (win == cfg.sync_byte)
                    begin
                        sync_next = 1'b1;
                        bits_next = abpd_pkg::BITS_TWO;
                    end
                    else
                    begin
                        bits_next = abpd_pkg::BITS_ONE;
                    end
                end
                else if (win == cfg.sync_byte)
                begin
                    bits_next = abpd_pkg::BITS_TWO;
                end
                else if (win == partial)
                begin
                    bits_next = abpd_pkg::BITS_SIX;
                end
                else if (win == cfg.dummy_byte)
                begin
                    aligned_next = 1'b1;
                    window_next  = 8'd0;
                    bits_next    = abpd_pkg::BITS_FULL_BYTE;
                end
                else
                begin
                    sync_next   = 1'b0;
                    window_next = 8'd0;
                    bits_next   = abpd_pkg::BITS_FULL_BYTE;
                    res_valid   = 1'b1;
                    res.kind    = abpd_pkg::EV_SYNC_LOST;
                end
            end
            else
            begin
                // byte aligned: one whole byte per pass
                window_next = 8'd0;
                bits_next   = abpd_pkg::BITS_FULL_BYTE;
                case (phase_reg)
                    abpd_pkg::PH_START:
                    begin
                        res_valid = 1'b1;
                        if (win == cfg.start_byte)
                        begin
                            phase_next = abpd_pkg::PH_LEN_HI;
                            res.kind   = abpd_pkg::EV_START;
                        end
                        else
                        begin
                            sync_next    = 1'b0;
                            aligned_next = 1'b0;
                            res.kind     = abpd_pkg::EV_SYNC_LOST;
                        end
                    end
                    abpd_pkg::PH_LEN_HI:
                    begin
                        len_next   = {digit[3:0], 4'd0};
                        phase_next = abpd_pkg::PH_LEN_LO;
                    end
                    abpd_pkg::PH_LEN_LO:
                    begin
                        len_next   = len_reg | digit;
                        count_next = 8'd0;
                        phase_next = abpd_pkg::PH_PAYLOAD;
                        res_valid  = 1'b1;
                        res.kind   = abpd_pkg::EV_LENGTH;
                        res.value  = len_reg | digit;
                    end
                    default:
                    begin
                        if (count_reg < len_reg)
                        begin
                            count_next = count_reg + 8'd1;
                            res_valid  = 1'b1;
                            res.kind   = abpd_pkg::EV_PAYLOAD;
                        end
                        else if (count_reg < cfg.slots)
                        begin
                            count_next = count_reg + 8'd1;
                        end
                        else
                        begin
                            res_valid    = 1'b1;
                            res.kind     = (win == cfg.end_byte) ? abpd_pkg::EV_END_OK
                                                                 : abpd_pkg::EV_END_BAD;
                            phase_next   = abpd_pkg::PH_START;
                            sync_next    = 1'b0;
                            aligned_next = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= 8'd0;
            bits_reg    <= abpd_pkg::BITS_FULL_BYTE;
            cal_reg     <= 1'b0;
            sync_reg    <= 1'b0;
            aligned_reg <= 1'b0;
            phase_reg   <= abpd_pkg::PH_START;
            len_reg     <= 8'd0;
            count_reg   <= 8'd0;
        end
        else
        begin
            window_reg  <= window_next;
            bits_reg    <= bits_next;
            cal_reg     <= cal_next;
            sync_reg    <= sync_next;
            aligned_reg <= aligned_next;
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
        end
    end

    // framing past the start byte only happens while aligned
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != abpd_pkg::PH_START) |-> aligned_reg)
        else $error("frame phase advanced without alignment");

    assert property (@(posedge clk) disable iff (!rst_n)
        aligned_reg |-> sync_reg)
        else $error("aligned without a sync byte seen");

    // a byte-level event always restarts bit counting on a clean window
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind != abpd_pkg::EV_CALIBRATED)
        |=> (bits_reg == abpd_pkg::BITS_FULL_BYTE && window_reg == 8'd0))
        else $error("window not restarted after framing event");

endmodule

// File: src/abpd_outq.sv
module abpd_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  abpd_pkg::res_t push_data,
    output logic           full,
    output logic           out_valid,
    input  logic           out_ready,
    output abpd_pkg::res_t out_data
);

    abpd_pkg::res_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg,  count_next;
    logic           pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("result pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    // pointers differ exactly when one word is held
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg != rd_ptr_reg) == (count_reg == 2'd1))
        else $error("queue pointers disagree with count");

endmodule

// File: src/ask_bit_packet_deframer.sv
// bit-serial sync-word deframer for a demodulated ask bit stream
//
// input channel: one received bit per word on rx_bit (in_valid / in_ready).
// output channel: event_kind and byte_value (out_valid / out_ready), at most
// one word per input bit: calibrated, sync lost, start seen, decoded length,
// payload byte, end ok or end bad.
// config channel: cfg_valid writes cfg_data to the register cfg_index picks;
// cfg_ready is always high. writes must go in while idle; it is not enforced.
//
// one bit is taken every cycle while in_ready is high. a result is computed
// in the same cycle the bit is accepted and is stored in the output queue.
// results wait in a two-word output queue, so a stalled receiver does not
// stop the bit stream until two words are pending; in_ready then drops
// until out_ready takes one.
// reset loads the register defaults, clears the window and the queue, and
// returns the framer to calibration (or sync hunt when calibration is off).
module ask_bit_packet_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       rx_bit,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_kind,
    output logic [7:0] byte_value,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    abpd_pkg::cfg_t cfg_reg, cfg_next;
    logic           accept;
    logic           res_valid;
    abpd_pkg::res_t res;
    abpd_pkg::res_t out_data;
    logic           q_full;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                abpd_pkg::REG_CAL_ENABLE:  cfg_next.cal_enable  = cfg_data[0];
                abpd_pkg::REG_CAL_PATTERN: cfg_next.cal_pattern = cfg_data;
                abpd_pkg::REG_SYNC_BYTE:   cfg_next.sync_byte   = cfg_data;
                abpd_pkg::REG_DUMMY_BYTE:  cfg_next.dummy_byte  = cfg_data;
                abpd_pkg::REG_START_BYTE:  cfg_next.start_byte  = cfg_data;
                abpd_pkg::REG_END_BYTE:    cfg_next.end_byte    = cfg_data;
                abpd_pkg::REG_SLOTS:       cfg_next.slots       = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_enable  <= abpd_pkg::RST_CAL_ENABLE;
            cfg_reg.cal_pattern <= abpd_pkg::RST_CAL_PATTERN;
            cfg_reg.sync_byte   <= abpd_pkg::RST_SYNC_BYTE;
            cfg_reg.dummy_byte  <= abpd_pkg::RST_DUMMY_BYTE;
            cfg_reg.start_byte  <= abpd_pkg::RST_START_BYTE;
            cfg_reg.end_byte    <= abpd_pkg::RST_END_BYTE;
            cfg_reg.slots       <= abpd_pkg::RST_SLOTS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    abpd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_bit    (rx_bit),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    abpd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (q_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign event_kind = out_data.kind;
    assign byte_value = out_data.value;

endmodule
